[rtl/circular_deque_macros.svh]
// Assertion macros for the circular deque.
// Included by the top level; no other dependencies.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every edge outside reset.
`define CDQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that the consequent holds on the edge after the antecedent.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CDQ_ASSERT(label, clk, rst_n, prop, msg)
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/cdq_pkg.sv]
// Shared constants, command and status codes and ring-pointer helpers
// for the circular deque. No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned PTR_W      = $clog2(DEPTH);
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Controller to datapath strobes
  typedef struct packed {
    logic capture;  // latch the incoming beat
    logic exec;     // run the command against pointers and storage
    logic load;     // move the result into the output register
  } ctrl_cmd_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  function automatic ptr_t ring_prev(input ptr_t p);
    ptr_t r;
    if (p == '0) r = PTR_W'(DEPTH - 1);
    else r = p - 1'b1;
    return r;
  endfunction

endpackage

[rtl/cdq_ctrl.sv]
// Sequencing state machine for the circular deque.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  output ctrl_cmd_t ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;
  assign out_free  = !out_valid_q || m_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    ctrl_o      = '0;
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        // hold the result until the output register is free
        if (out_free) begin
          ctrl_o.load = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/cdq_dp.sv]
// Datapath of the circular deque: ring pointers, slot storage and the
// result register. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_dp
  import cdq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           ctrl_i,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [DATA_W-1:0]   item_i,
  output logic [DATA_W-1:0]   value_o,
  output logic [STATUS_W-1:0] status_o,
  output logic                now_empty_o,
  output logic                now_full_o
);

  logic [DATA_W-1:0] slots [DEPTH];

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] item_q;
  ptr_t              head_q, head_d;
  ptr_t              tail_q, tail_d;
  status_e           status_q, status_d;
  logic              rd_ok_q, rd_ok_d;
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  ptr_t              mem_addr;
  logic              ring_empty, is_full;

  logic [DATA_W-1:0]   value_q;
  logic [STATUS_W-1:0] status_out_q;
  logic                empty_out_q, full_out_q;

  assign ring_empty = (head_q == tail_q);
  assign is_full    = (ring_next(tail_q) == head_q);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    status_d = status_q;
    rd_ok_d  = rd_ok_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = tail_q;
    if (ctrl_i.exec) begin
      status_d = STATUS_OK;
      rd_ok_d  = 1'b0;
      case (cmd_q)
        CMD_PUSH_FRONT: begin
          if (is_full) begin
            status_d = STATUS_FULL;
          end else begin
            mem_we   = 1'b1;
            mem_addr = head_q;
            head_d   = ring_prev(head_q);
          end
        end
        CMD_PUSH_REAR: begin
          if (is_full) begin
            status_d = STATUS_FULL;
          end else begin
            mem_we   = 1'b1;
            mem_addr = ring_next(tail_q);
            tail_d   = ring_next(tail_q);
          end
        end
        CMD_POP_FRONT: begin
          if (ring_empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            mem_re   = 1'b1;
            rd_ok_d  = 1'b1;
            mem_addr = ring_next(head_q);
            head_d   = ring_next(head_q);
          end
        end
        CMD_POP_REAR: begin
          if (ring_empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            mem_re   = 1'b1;
            rd_ok_d  = 1'b1;
            tail_d   = ring_prev(tail_q);
          end
        end
        CMD_PEEK_FRONT: begin
          if (ring_empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            mem_re   = 1'b1;
            rd_ok_d  = 1'b1;
            mem_addr = ring_next(head_q);
          end
        end
        CMD_PEEK_REAR: begin
          if (ring_empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            mem_re   = 1'b1;
            rd_ok_d  = 1'b1;
          end
        end
        default: begin
          // unused codes leave pointers and storage as they are and report OK
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) slots[mem_addr] <= item_q;
    if (mem_re) rdata_q <= slots[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rd_ok_q  <= rd_ok_d;
    if (ctrl_i.capture) begin
      cmd_q  <= cmd_i;
      item_q <= item_i;
    end
    // pointers are already updated here, so the flags describe the new state
    if (ctrl_i.load) begin
      value_q      <= rd_ok_q ? rdata_q : '0;
      status_out_q <= status_q;
      empty_out_q  <= ring_empty;
      full_out_q   <= is_full;
    end
  end

  assign value_o     = value_q;
  assign status_o    = status_out_q;
  assign now_empty_o = empty_out_q;
  assign now_full_o  = full_out_q;

endmodule

[rtl/circular_deque.sv]
// Circular deque, top level: stream wrapper around cdq_ctrl and cdq_dp.
// Each command beat is captured, executed on the single-port slot memory (registered
// read) and pointers, then its result is loaded into the output register once that
// register is free; no new command is taken until the previous result is loaded.
// Reset (rst_ni, async, active low) empties the deque; slot contents are kept.
`timescale 1ns / 1ps
`include "circular_deque_macros.svh"

module circular_deque
  import cdq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Command side
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [DATA_W-1:0]      s_axis_tdata_i,   // [31:0] item
  input  logic [CMD_W-1:0]       s_axis_tuser_i,   // [2:0] cmd
  // Result side
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [31:0] value, [32] now_empty,
                                                   // [33] now_full, [39:34] zero
  output logic [STATUS_W-1:0]    m_axis_tuser_o    // [1:0] status
);

  ctrl_cmd_t         ctrl;
  logic [DATA_W-1:0] value;
  logic              now_empty;
  logic              now_full;

  // The controller walks each beat through capture, execute and load; the
  // output register lets a new command beat be taken while the previous
  // result still waits on the master side.
  cdq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .ctrl_o    (ctrl)
  );

  // Pointers, slot memory and result registers.
  cdq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cmd_i       (s_axis_tuser_i),
    .item_i      (s_axis_tdata_i),
    .value_o     (value),
    .status_o    (m_axis_tuser_o),
    .now_empty_o (now_empty),
    .now_full_o  (now_full)
  );

  // Pack the result beat, lowest field first, zero padded to whole bytes.
  assign m_axis_tdata_o = {(OUT_TDATA_W - DATA_W - 2)'(0), now_full, now_empty, value};

  // One command in flight: ready drops straight after a beat is taken.
  `CDQ_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "command taken while another is in flight")
  // A ring of at least two slots is never empty and full at once.
  `CDQ_ASSERT(a_flags_exclusive, clk_i, rst_ni, m_axis_tvalid_o |-> !(now_empty && now_full), "result flags both set")
  // Only defined status codes leave the block.
  `CDQ_ASSERT(a_status_code, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tuser_o == STATUS_OK || m_axis_tuser_o == STATUS_FULL || m_axis_tuser_o == STATUS_EMPTY), "undefined status code")
  // A rejected command never returns data.
  `CDQ_ASSERT(a_reject_zero, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o != STATUS_OK) |-> (value == '0), "rejected command returned data")

endmodule

[tb/testbench.sv]
// Self-checking testbench for circular_deque: streams push, pop and peek
// commands, predicts every result in a scoreboard class and compares them.
// Depends on cdq_pkg and the circular_deque RTL only.
`timescale 1ns / 1ps

typedef struct packed {
  logic [cdq_pkg::DATA_W-1:0]   value;
  logic [cdq_pkg::STATUS_W-1:0] status;
  logic                         now_empty;
  logic                         now_full;
} deque_result_t;

// Mirror of the deque: ring storage, both pointers and the queue of results
// still owed by the block.
class deque_scoreboard;
  logic [cdq_pkg::DATA_W-1:0] ring [cdq_pkg::DEPTH];
  cdq_pkg::ptr_t              head;
  cdq_pkg::ptr_t              tail;
  deque_result_t              awaited [$];
  int                         errors;
  int                         results_seen;
  int                         commands_seen;
  int                         full_rejects;
  int                         empty_rejects;
  int                         spare_cmds;

  function new();
    foreach (ring[i]) ring[i] = '0;
    head          = '0;
    tail          = '0;
    errors        = 0;
    results_seen  = 0;
    commands_seen = 0;
    full_rejects  = 0;
    empty_rejects = 0;
    spare_cmds    = 0;
  endfunction

  function cdq_pkg::ptr_t step_up(cdq_pkg::ptr_t p);
    return cdq_pkg::ptr_t'((int'(p) + 1) % cdq_pkg::DEPTH);
  endfunction

  function cdq_pkg::ptr_t step_down(cdq_pkg::ptr_t p);
    return cdq_pkg::ptr_t'((int'(p) + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH);
  endfunction

  function bit ring_empty();
    return head == tail;
  endfunction

  function bit is_full();
    return step_up(tail) == head;
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", msg);
  endtask

  // Apply one accepted command beat to the mirror and queue its result.
  function void note_command(logic [cdq_pkg::CMD_W-1:0] cmd,
                             logic [cdq_pkg::DATA_W-1:0] item);
    deque_result_t r;
    r.value  = '0;
    r.status = cdq_pkg::STATUS_OK;
    commands_seen++;
    case (cmd)
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (is_full()) begin
          r.status = cdq_pkg::STATUS_FULL;
        end else begin
          ring[head] = item;
          head = step_down(head);
        end
      end
      cdq_pkg::CMD_PUSH_REAR: begin
        if (is_full()) begin
          r.status = cdq_pkg::STATUS_FULL;
        end else begin
          tail = step_up(tail);
          ring[tail] = item;
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (ring_empty()) begin
          r.status = cdq_pkg::STATUS_EMPTY;
        end else begin
          head = step_up(head);
          r.value = ring[head];
        end
      end
      cdq_pkg::CMD_POP_REAR: begin
        if (ring_empty()) begin
          r.status = cdq_pkg::STATUS_EMPTY;
        end else begin
          r.value = ring[tail];
          tail = step_down(tail);
        end
      end
      cdq_pkg::CMD_PEEK_FRONT: begin
        if (ring_empty()) r.status = cdq_pkg::STATUS_EMPTY;
        else r.value = ring[step_up(head)];
      end
      cdq_pkg::CMD_PEEK_REAR: begin
        if (ring_empty()) r.status = cdq_pkg::STATUS_EMPTY;
        else r.value = ring[tail];
      end
      default: begin
        // spare codes leave the deque alone but still answer
        spare_cmds++;
      end
    endcase
    r.now_empty = ring_empty();
    r.now_full  = is_full();
    if (r.status == cdq_pkg::STATUS_FULL) full_rejects++;
    if (r.status == cdq_pkg::STATUS_EMPTY) empty_rejects++;
    awaited.push_back(r);
  endfunction

  // Compare one accepted result beat with the oldest outstanding prediction.
  task check_result(deque_result_t got);
    deque_result_t want;
    results_seen++;
    if (awaited.size() == 0) begin
      report($sformatf("result %0d arrived with nothing outstanding (value %h)",
                       results_seen, got.value));
      return;
    end
    want = awaited.pop_front();
    if (got.value !== want.value)
      report($sformatf("result %0d value %h, predicted %h",
                       results_seen, got.value, want.value));
    if (got.status !== want.status)
      report($sformatf("result %0d status %0d, predicted %0d",
                       results_seen, got.status, want.status));
    if (got.now_empty !== want.now_empty)
      report($sformatf("result %0d empty flag %b, predicted %b",
                       results_seen, got.now_empty, want.now_empty));
    if (got.now_full !== want.now_full)
      report($sformatf("result %0d full flag %b, predicted %b",
                       results_seen, got.now_full, want.now_full));
  endtask
endclass

module testbench;
  import cdq_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 8;

  // spare command codes that the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] ZERO     = 32'h0000_0000;

  logic                   clk_i;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [DATA_W-1:0]      s_axis_tdata_i  = '0;
  logic [CMD_W-1:0]       s_axis_tuser_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]    m_axis_tuser_o;

  deque_scoreboard sb;
  bit              calm = 1'b0;   // no idling on either side while set
  int              cycles = 0;

  circular_deque dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_item();
    int r;
    r = $urandom_range(0, 99);
    case (r % 4)
      0: if (r < 12) return MOST_NEG;
      1: if (r < 12) return MOST_POS;
      2: if (r < 12) return ALL_ONES;
      default: if (r < 12) return ZERO;
    endcase
    return $urandom;
  endfunction

  // Offer one command beat, hold it until taken, then predict its result.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= item;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_command(cmd, item);
  endtask

  // Draw a command; push_pct steers the fill level towards full or empty.
  task automatic send_random(input int push_pct);
    int                 r;
    logic [CMD_W-1:0]   cmd;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    end else if (r < 16) begin
      cmd = $urandom_range(0, 1) ? CMD_PEEK_REAR : CMD_PEEK_FRONT;
    end else if ($urandom_range(0, 99) < push_pct) begin
      cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    end else begin
      cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
    end
    send_cmd(cmd, pick_item());
  endtask

  // Result side: bursts of ready broken by random stalls.
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Check every result beat as it is taken.
  always @(posedge clk_i) begin
    deque_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.value     = m_axis_tdata_o[31:0];
      got.now_empty = m_axis_tdata_o[32];
      got.now_full  = m_axis_tdata_o[33];
      got.status    = m_axis_tuser_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.awaited.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int sent;
    int run_len;
    int push_pct;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rejects on empty, spare codes, extremes at both ends,
    // fill to full, rejects on full, then take from both ends.
    send_cmd(CMD_POP_FRONT, MOST_POS);
    send_cmd(CMD_POP_REAR, MOST_NEG);
    send_cmd(CMD_PEEK_FRONT, ALL_ONES);
    send_cmd(CMD_PEEK_REAR, ZERO);
    send_cmd(CMD_SPARE_LO, ALL_ONES);
    send_cmd(CMD_PUSH_FRONT, MOST_POS);
    send_cmd(CMD_PUSH_REAR, MOST_NEG);
    send_cmd(CMD_PEEK_FRONT, ZERO);
    send_cmd(CMD_PEEK_REAR, ZERO);
    send_cmd(CMD_SPARE_HI, MOST_NEG);
    for (int i = 0; i < DEPTH - 3; i++) begin
      send_cmd((i % 2) ? CMD_PUSH_REAR : CMD_PUSH_FRONT,
               (i % 3 == 0) ? ALL_ONES : (i % 3 == 1) ? ZERO : DATA_W'(i * 32'h1111_1111));
    end
    send_cmd(CMD_PUSH_FRONT, ALL_ONES);
    send_cmd(CMD_PUSH_REAR, ZERO);
    send_cmd(CMD_POP_FRONT, ZERO);
    send_cmd(CMD_POP_REAR, ZERO);

    // Random: runs that lean towards filling, draining or neither.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 80;
        1: push_pct = 20;
        default: push_pct = 50;
      endcase
      calm = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        send_random(push_pct);
        sent++;
      end
    end
    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    // Drain: wait for every owed result, then a few cycles for strays.
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands and checked %0d results (%0d spare codes).",
             sb.commands_seen, sb.results_seen, sb.spare_cmds);
    $display("Pushes turned away when full: %0d; pops or peeks on empty: %0d.",
             sb.full_rejects, sb.empty_rejects);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_dp.sv
rtl/circular_deque.sv
tb/testbench.sv
